FILE: hdl/qs_pkg.sv
package qs_pkg;

    // Fixed-point format of all quaternion components and angles.
    localparam int FRAC_BITS = 30;
    localparam logic [30:0] ONE = 31'(1) << FRAC_BITS;
    localparam logic [61:0] ONE_SQ = 62'(1) << (2 * FRAC_BITS);
    localparam logic [31:0] GAIN_INV = 32'd652032874;

    // Datapath widths.
    localparam int SQ_W = 62;   // radicand and root work registers
    localparam int XY_W = 34;   // CORDIC x and y
    localparam int Z_W = 33;    // CORDIC angle accumulator
    localparam int REM_W = 63;  // divider remainder
    localparam int QUO_W = 31;  // divider quotient

    // Pipeline map: index of the stage register that holds each result.
    localparam int SQRT_CELLS = 31;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_CELLS = 31;
    localparam int ST_DOT = 1;
    localparam int ST_SQ = 2;
    localparam int ST_SQRT0 = 3;
    localparam int ST_VEC0 = ST_SQRT0 + SQRT_CELLS;
    localparam int ST_THETA = ST_VEC0 + CORDIC_STEPS;
    localparam int ST_SIN0 = ST_THETA + 1;
    localparam int ST_MUL = ST_SIN0 + CORDIC_STEPS;
    localparam int ST_NUM = ST_MUL + 1;
    localparam int ST_DIV0 = ST_NUM + 1;
    localparam int NSTG = ST_DIV0 + DIV_CELLS;

    // Configuration register map (word index).
    localparam logic REG_MARGIN = 1'b0;
    localparam logic [10:0] MARGIN_RESET = 11'd1;

    // Side data that rides along the pipeline next to the arithmetic cells.
    typedef struct packed {
        logic [3:0][31:0] f;
        logic [3:0][31:0] g;
        logic [30:0]      t;
        logic             neg;
        logic             copy;
        logic [30:0]      d30;
        logic [30:0]      sn;
        logic [3:0]       rneg;
        logic [3:0]       big;
    } t_side;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic logic [32:0] step_angle(input int unsigned i);
        logic [32:0] a;
        case (i)
            0:       a = 33'd843314857;
            1:       a = 33'd497837829;
            2:       a = 33'd263043837;
            3:       a = 33'd133525159;
            4:       a = 33'd67021687;
            5:       a = 33'd33543516;
            6:       a = 33'd16775851;
            7:       a = 33'd8388437;
            8:       a = 33'd4194283;
            9:       a = 33'd2097149;
            default: a = 33'(1) << (FRAC_BITS - i);
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/quaternion_slerp.sv
// Channel   Direction  Handshake                     Contents
// item in   input      start, accepted when !busy    i_from_*, i_to_*, i_t_fraction
// result    output     o_done, one cycle, no stall   o_out_*, o_took_copy
// config    in/out     APB write on psel&penable     closeness_margin at word 0
//
// The block is a straight pipeline: one item may be started in every clock
// cycle and busy never rises. The pipeline is built from chains of cells:
// 31 square-root cells, 30 angle cells, 30 sine cells (two chains side by
// side) and 31 divider cells. Reset clears the valid bits of all stages and
// sets the margin to one. The receiver cannot stall, so nothing in the pipe
// ever waits.
module quaternion_slerp import qs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [31:0] i_from_x,
    input  logic [31:0] i_from_y,
    input  logic [31:0] i_from_z,
    input  logic [31:0] i_from_w,
    input  logic [31:0] i_to_x,
    input  logic [31:0] i_to_y,
    input  logic [31:0] i_to_z,
    input  logic [31:0] i_to_w,
    input  logic [30:0] i_t_fraction,
    output logic        o_done,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [31:0] o_out_w,
    output logic        o_took_copy
);

    localparam logic signed [31:0] ONE_S = 32'(ONE);

    // ---------------------------------------------------------------
    // Configuration register. The word address is paddr[2].
    // ---------------------------------------------------------------
    logic [10:0] r_margin;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr[2] == REG_MARGIN) ? {21'd0, r_margin} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MARGIN) begin
            r_margin <= pwdata[10:0];
        end
    end

    // ---------------------------------------------------------------
    // Valid bits and the side data that travels with each item.
    // ---------------------------------------------------------------
    logic [NSTG-1:0] r_valid;
    t_side           r_side [NSTG];
    t_side           n_side0, n_side_dot, n_side_vec, n_side_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_done  <= 1'b0;
        end else begin
            r_valid <= {r_valid[NSTG-2:0], start};
            o_done  <= r_valid[NSTG-1];
        end
    end

    // Capture of a new item; the fraction is saturated to one here.
    always_comb begin
        n_side0      = '0;
        n_side0.f[0] = i_from_x;
        n_side0.f[1] = i_from_y;
        n_side0.f[2] = i_from_z;
        n_side0.f[3] = i_from_w;
        n_side0.g[0] = i_to_x;
        n_side0.g[1] = i_to_y;
        n_side0.g[2] = i_to_z;
        n_side0.g[3] = i_to_w;
        n_side0.t    = (i_t_fraction > ONE) ? ONE : i_t_fraction;
    end

    // ---------------------------------------------------------------
    // Stage 0: the four component products of the dot product.
    // ---------------------------------------------------------------
    logic signed [63:0] r_prod [4];

    always_ff @(posedge i_clk) begin
        r_prod[0] <= $signed(i_from_x) * $signed(i_to_x);
        r_prod[1] <= $signed(i_from_y) * $signed(i_to_y);
        r_prod[2] <= $signed(i_from_z) * $signed(i_to_z);
        r_prod[3] <= $signed(i_from_w) * $signed(i_to_w);
    end

    // ---------------------------------------------------------------
    // Stage 1: dot product, its magnitude and the near-zero-angle test.
    // Each product is floored to Q30 before the exact sum.
    // ---------------------------------------------------------------
    logic signed [35:0] dot;
    logic        [35:0] dot_mag;

    always_comb begin
        dot = 36'(r_prod[0] >>> FRAC_BITS) + 36'(r_prod[1] >>> FRAC_BITS)
            + 36'(r_prod[2] >>> FRAC_BITS) + 36'(r_prod[3] >>> FRAC_BITS);
        dot_mag = (dot < 0) ? 36'(-dot) : 36'(dot);
        n_side_dot      = r_side[ST_DOT-1];
        n_side_dot.neg  = dot < 0;
        n_side_dot.copy = dot_mag > 36'(ONE - 31'(r_margin));
        n_side_dot.d30  = dot_mag[30:0];
    end

    // ---------------------------------------------------------------
    // Stage 2: square of the cosine, ahead of the square-root chain.
    // ---------------------------------------------------------------
    logic [61:0] r_sq;

    always_ff @(posedge i_clk) begin
        r_sq <= r_side[ST_DOT].d30 * r_side[ST_DOT].d30;
    end

    // ---------------------------------------------------------------
    // Square-root chain: sin(theta) = sqrt(1 - d^2), one bit per cell.
    // ---------------------------------------------------------------
    logic [SQ_W-1:0] sq_rem  [SQRT_CELLS+1];
    logic [SQ_W-1:0] sq_root [SQRT_CELLS+1];

    assign sq_rem[0]  = ONE_SQ - r_sq;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        qs_sqrt_cell #(.STEP(j)) u_cell (
            .i_clk  (i_clk),
            .i_rem  (sq_rem[j]),
            .i_root (sq_root[j]),
            .o_rem  (sq_rem[j+1]),
            .o_root (sq_root[j+1])
        );
    end

    // A zero sine also falls back to copying the first quaternion.
    always_comb begin
        n_side_vec      = r_side[ST_VEC0-1];
        n_side_vec.sn   = sq_root[SQRT_CELLS][30:0];
        n_side_vec.copy = r_side[ST_VEC0-1].copy || (sq_root[SQRT_CELLS][30:0] == '0);
    end

    // ---------------------------------------------------------------
    // Vectoring chain: theta = atan2(sin, cos).
    // ---------------------------------------------------------------
    logic signed [XY_W-1:0] vx [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] vy [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  vz [CORDIC_STEPS+1];

    assign vx[0] = $signed(XY_W'(r_side[ST_VEC0-1].d30));
    assign vy[0] = $signed(XY_W'(sq_root[SQRT_CELLS][30:0]));
    assign vz[0] = '0;

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_vec
        qs_cordic_cell #(.STEP(j), .VECTORING(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_x   (vx[j]),
            .i_y   (vy[j]),
            .i_z   (vz[j]),
            .o_x   (vx[j+1]),
            .o_y   (vy[j+1]),
            .o_z   (vz[j+1])
        );
    end

    // ---------------------------------------------------------------
    // Theta stage: clamp a negative angle to zero and scale by t.
    // ---------------------------------------------------------------
    logic [30:0] theta;
    logic [30:0] r_theta;
    logic [61:0] r_theta_t;

    assign theta = (vz[CORDIC_STEPS] < 0) ? 31'd0 : vz[CORDIC_STEPS][30:0];

    always_ff @(posedge i_clk) begin
        r_theta   <= theta;
        r_theta_t <= theta * r_side[ST_THETA-1].t;
    end

    // ---------------------------------------------------------------
    // Two rotation chains side by side: sin((1-t)theta) and sin(t theta).
    // ---------------------------------------------------------------
    logic [30:0]            a1, a0;
    logic signed [XY_W-1:0] sx [2][CORDIC_STEPS+1];
    logic signed [XY_W-1:0] sy [2][CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  sz [2][CORDIC_STEPS+1];

    assign a1 = r_theta_t[60:30];
    assign a0 = r_theta - a1;

    assign sz[0][0] = $signed(Z_W'(a0));
    assign sz[1][0] = $signed(Z_W'(a1));

    for (genvar h = 0; h < 2; h++) begin : g_sin
        assign sx[h][0] = $signed(XY_W'(GAIN_INV));
        assign sy[h][0] = '0;
        for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
            qs_cordic_cell #(.STEP(j), .VECTORING(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_x   (sx[h][j]),
                .i_y   (sy[h][j]),
                .i_z   (sz[h][j]),
                .o_x   (sx[h][j+1]),
                .o_y   (sy[h][j+1]),
                .o_z   (sz[h][j+1])
            );
        end
    end

    // ---------------------------------------------------------------
    // Weighting: the second weight is negated for the shorter arc.
    // ---------------------------------------------------------------
    logic signed [31:0] s0, s1;
    logic signed [63:0] r_m0 [4];
    logic signed [63:0] r_m1 [4];

    assign s0 = sy[0][CORDIC_STEPS][31:0];
    assign s1 = r_side[ST_MUL-1].neg ? -sy[1][CORDIC_STEPS][31:0]
                                     : sy[1][CORDIC_STEPS][31:0];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_m0[c] <= $signed(r_side[ST_MUL-1].f[c]) * s0;
            r_m1[c] <= $signed(r_side[ST_MUL-1].g[c]) * s1;
        end
    end

    // ---------------------------------------------------------------
    // Numerator stage: sign, magnitude and the overflow test that lets
    // the divider stop at 31 quotient bits.
    // ---------------------------------------------------------------
    logic signed [63:0] num [4];
    logic [REM_W-1:0]   num_mag [4];
    logic [REM_W-1:0]   r_num_mag [4];

    always_comb begin
        n_side_num = r_side[ST_NUM-1];
        for (int c = 0; c < 4; c++) begin
            num[c]     = r_m0[c] + r_m1[c];
            num_mag[c] = (num[c] < 0) ? REM_W'(-num[c]) : REM_W'(num[c]);
            n_side_num.rneg[c] = num[c] < 0;
            n_side_num.big[c]  = num_mag[c] >= {1'b0, r_side[ST_NUM-1].sn, 31'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_num_mag[c] <= num_mag[c];
        end
    end

    // ---------------------------------------------------------------
    // Divider chains, one per component, one quotient bit per cell.
    // ---------------------------------------------------------------
    logic [REM_W-1:0] dv_rem [4][DIV_CELLS+1];
    logic [QUO_W-1:0] dv_quo [4][DIV_CELLS+1];

    for (genvar c = 0; c < 4; c++) begin : g_lane
        assign dv_rem[c][0] = r_num_mag[c];
        assign dv_quo[c][0] = '0;
        for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
            qs_div_cell #(.BIT(DIV_CELLS - 1 - j)) u_cell (
                .i_clk (i_clk),
                .i_rem (dv_rem[c][j]),
                .i_quo (dv_quo[c][j]),
                .i_div (r_side[ST_DIV0+j-1].sn),
                .o_rem (dv_rem[c][j+1]),
                .o_quo (dv_quo[c][j+1])
            );
        end
    end

    // ---------------------------------------------------------------
    // Side data shift register with its per-stage updates.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side0;
        for (int k = 1; k < NSTG; k++) begin
            if (k == ST_DOT) begin
                r_side[k] <= n_side_dot;
            end else if (k == ST_VEC0) begin
                r_side[k] <= n_side_vec;
            end else if (k == ST_NUM) begin
                r_side[k] <= n_side_num;
            end else begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: saturate, restore the sign, or pass the copy through.
    // ---------------------------------------------------------------
    t_side       last;
    logic [31:0] res [4];
    logic [30:0] qmag;

    assign last = r_side[NSTG-1];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            qmag = (last.big[c] || dv_quo[c][DIV_CELLS] > ONE) ? ONE : dv_quo[c][DIV_CELLS];
            if (last.copy) begin
                res[c] = last.f[c];
            end else if (last.rneg[c]) begin
                res[c] = -{1'b0, qmag};
            end else begin
                res[c] = {1'b0, qmag};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_x     <= res[0];
        o_out_y     <= res[1];
        o_out_z     <= res[2];
        o_out_w     <= res[3];
        o_took_copy <= last.copy;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // An interpolated result never leaves the unit range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_took_copy |->
            $signed(o_out_x) <= ONE_S && $signed(o_out_x) >= -ONE_S &&
            $signed(o_out_y) <= ONE_S && $signed(o_out_y) >= -ONE_S &&
            $signed(o_out_z) <= ONE_S && $signed(o_out_z) >= -ONE_S &&
            $signed(o_out_w) <= ONE_S && $signed(o_out_w) >= -ONE_S)
        else $error("interpolated component outside the unit range");

    // An item that goes on to be interpolated has a cosine of at most one.
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_DOT] && !r_side[ST_DOT].copy |-> r_side[ST_DOT].d30 <= ONE)
        else $error("cosine above one on the interpolation path");

    // The divider never sees a zero sine for an interpolated item.
    a_sine_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_VEC0] && !r_side[ST_VEC0].copy |-> r_side[ST_VEC0].sn != '0)
        else $error("zero sine reached the divider");

endmodule

FILE: hdl/qs_sqrt_cell.sv
module qs_sqrt_cell import qs_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic [SQ_W-1:0] i_rem,
    input  logic [SQ_W-1:0] i_root,
    output logic [SQ_W-1:0] o_rem,
    output logic [SQ_W-1:0] o_root
);

    // One result bit per cell; the trial bit walks down two places per cell.
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * FRAC_BITS - 2 * STEP);

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_rem, n_root;
    logic [SQ_W-1:0] r_rem, r_root;

    always_comb begin
        trial = i_root + BIT;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: hdl/qs_cordic_cell.sv
module qs_cordic_cell import qs_pkg::*; #(
    parameter int STEP      = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                   i_clk,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic signed [Z_W-1:0]  o_z
);

    localparam logic signed [Z_W-1:0] ANG = step_angle(STEP);

    logic signed [XY_W-1:0] xs, ys;
    logic                   ccw;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;

    // Arithmetic shifts round toward minus infinity.
    assign xs  = i_x >>> STEP;
    assign ys  = i_y >>> STEP;
    // Vectoring drives y to zero, rotation drives z to zero.
    assign ccw = VECTORING ? (i_y < 0) : (i_z >= 0);

    always_ff @(posedge i_clk) begin
        if (ccw) begin
            r_x <= i_x - ys;
            r_y <= i_y + xs;
            r_z <= i_z - ANG;
        end else begin
            r_x <= i_x + ys;
            r_y <= i_y - xs;
            r_z <= i_z + ANG;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hdl/qs_div_cell.sv
module qs_div_cell import qs_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_quo,
    input  logic [30:0]       i_div,
    output logic [REM_W-1:0]  o_rem,
    output logic [QUO_W-1:0]  o_quo
);

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;

    assign shifted = REM_W'(i_div) << BIT;

    always_ff @(posedge i_clk) begin
        if (i_rem >= shifted) begin
            r_rem <= i_rem - shifted;
            r_quo <= i_quo | (QUO_W'(1) << BIT);
        end else begin
            r_rem <= i_rem;
            r_quo <= i_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule
